### hw/rtl/tsrg_pkg.sv
`timescale 1ns / 1ps

package tsrg_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register indexes
  localparam logic [2:0] REG_TARGET_SPEED   = 3'd0;
  localparam logic [2:0] REG_ACCEL_RATE     = 3'd1;
  localparam logic [2:0] REG_DECEL_RATE     = 3'd2;
  localparam logic [2:0] REG_TOTAL_STEPS    = 3'd3;
  localparam logic [2:0] REG_MOVE_DIRECTION = 3'd4;
  localparam logic [2:0] REG_PERIOD_BASE    = 3'd5;

  // register reset values
  localparam logic [15:0] RST_TARGET_SPEED = 16'd1000;
  localparam logic [15:0] RST_ACCEL_RATE   = 16'd100;
  localparam logic [15:0] RST_DECEL_RATE   = 16'd100;
  localparam logic [31:0] RST_TOTAL_STEPS  = 32'd100000;
  localparam logic        RST_MOVE_DIR     = 1'b0;
  localparam logic [31:0] RST_PERIOD_BASE  = 32'd1000000;

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_RAMP  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ACCEL = 3'd1;
  localparam logic [2:0] PH_RUN   = 3'd2;
  localparam logic [2:0] PH_DECEL = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  typedef enum logic [2:0] {
    SEL_UP   = 3'd0,
    SEL_DOWN = 3'd1,
    SEL_AINC = 3'd2,
    SEL_DINC = 3'd3,
    SEL_PER  = 3'd4
  } div_sel_e;

  typedef struct packed {
    logic [15:0] target_speed;
    logic [15:0] accel_rate;
    logic [15:0] decel_rate;
    logic [31:0] total_steps;
    logic        move_direction;
    logic [31:0] period_base;
  } cfg_t;

  typedef struct packed {
    logic     clr;
    logic     sq_ld;
    logic     div_go;
    div_sel_e go_sel;
    logic     res_ld;
    div_sel_e ld_sel;
    logic     commit;
    logic     reject;
    logic     step;
    logic     ramp;
    logic     stop;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic moving;
    logic plan_ok;
  } stat_t;

  typedef struct packed {
    logic        step_level;
    logic        direction_out;
    logic [31:0] period_value;
    logic        period_write;
    logic [2:0]  phase;
    logic        move_rejected;
  } res_t;

endpackage

### hw/rtl/tsrg_div.sv
`timescale 1ns / 1ps

module tsrg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [31:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] dvs_q, dvs_d;
  logic [33:0] shifted;
  logic [33:0] diff;

  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // one quotient bit per cycle
      if (!diff[33]) begin
        rem_d = diff[32:0];
      end else begin
        rem_d = shifted[32:0];
      end
      quo_d = {quo_q[30:0], ~diff[33]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hw/rtl/tsrg_dpath.sv
`timescale 1ns / 1ps

module tsrg_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsrg_pkg::cfg_t cfg_i,
  input  tsrg_pkg::cmd_t cmd_i,
  output tsrg_pkg::stat_t stat_o,
  output tsrg_pkg::res_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic        pulse_q, pulse_d;
  logic        dir_q, dir_d;
  logic [31:0] accel_left_q, accel_left_d;
  logic [31:0] cruise_left_q, cruise_left_d;
  logic [31:0] decel_left_q, decel_left_d;
  logic [31:0] ainc_q, ainc_d;
  logic [31:0] dinc_q, dinc_d;
  logic [31:0] speed_q, speed_d;
  logic [31:0] cper_q, cper_d;
  logic [31:0] wper_q, wper_d;
  logic        wrote_q, wrote_d;
  logic        rej_q, rej_d;
  logic [31:0] sq_q;
  logic [31:0] up_q, up_d;
  logic [31:0] down_q, down_d;

  logic [31:0] div_dividend;
  logic [32:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quo;
  logic [32:0] ramp_sum;
  logic [32:0] speed_sum;
  logic        moving;

  tsrg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  always_comb begin
    unique case (cmd_i.go_sel)
      tsrg_pkg::SEL_UP: begin
        div_dividend = sq_q;
        div_divisor  = {17'd0, cfg_i.accel_rate};
      end
      tsrg_pkg::SEL_DOWN: begin
        div_dividend = sq_q;
        div_divisor  = {17'd0, cfg_i.decel_rate};
      end
      tsrg_pkg::SEL_AINC: begin
        div_dividend = {16'd0, cfg_i.target_speed};
        div_divisor  = {1'b0, up_q};
      end
      tsrg_pkg::SEL_DINC: begin
        div_dividend = {16'd0, cfg_i.target_speed};
        div_divisor  = {1'b0, down_q};
      end
      tsrg_pkg::SEL_PER: begin
        div_dividend = cfg_i.period_base;
        div_divisor  = {1'b0, speed_q} + 33'd1;
      end
      default: begin
        div_dividend = cfg_i.period_base;
        div_divisor  = {1'b0, speed_q} + 33'd1;
      end
    endcase
  end

  assign moving = (phase_q == tsrg_pkg::PH_ACCEL) || (phase_q == tsrg_pkg::PH_RUN) ||
                  (phase_q == tsrg_pkg::PH_DECEL);
  assign ramp_sum  = {1'b0, up_q} + {1'b0, down_q};
  assign speed_sum = {1'b0, speed_q} + {1'b0, ainc_q};

  assign stat_o.div_done = div_done;
  assign stat_o.moving   = moving;
  assign stat_o.plan_ok  = (up_q != '0) && (down_q != '0) &&
                           (ramp_sum < {1'b0, cfg_i.total_steps});

  always_comb begin
    phase_d       = phase_q;
    pulse_d       = pulse_q;
    dir_d         = dir_q;
    accel_left_d  = accel_left_q;
    cruise_left_d = cruise_left_q;
    decel_left_d  = decel_left_q;
    ainc_d        = ainc_q;
    dinc_d        = dinc_q;
    speed_d       = speed_q;
    cper_d        = cper_q;
    wper_d        = wper_q;
    wrote_d       = wrote_q;
    rej_d         = rej_q;
    up_d          = up_q;
    down_d        = down_q;

    if (cmd_i.clr) begin
      wrote_d = 1'b0;
      rej_d   = 1'b0;
    end

    if (cmd_i.res_ld) begin
      unique case (cmd_i.ld_sel)
        tsrg_pkg::SEL_UP:   up_d   = (cfg_i.accel_rate == '0) ? '0 : {1'b0, div_quo[31:1]};
        tsrg_pkg::SEL_DOWN: down_d = (cfg_i.decel_rate == '0) ? '0 : {1'b0, div_quo[31:1]};
        tsrg_pkg::SEL_AINC: ainc_d = div_quo;
        tsrg_pkg::SEL_DINC: dinc_d = div_quo;
        tsrg_pkg::SEL_PER:  cper_d = div_quo;
        default:            cper_d = div_quo;
      endcase
    end

    if (cmd_i.commit) begin
      accel_left_d  = up_q;
      decel_left_d  = down_q;
      cruise_left_d = cfg_i.total_steps - up_q - down_q;
      speed_d       = '0;
      dir_d         = cfg_i.move_direction;
      phase_d       = tsrg_pkg::PH_ACCEL;
    end

    if (cmd_i.reject) begin
      rej_d = 1'b1;
    end

    if (cmd_i.step && moving) begin
      pulse_d = ~pulse_q;
      if (!pulse_q) begin
        if (phase_q == tsrg_pkg::PH_RUN) begin
          cruise_left_d = cruise_left_q - 32'd1;
          if (cruise_left_q == 32'd1) begin
            phase_d = tsrg_pkg::PH_DECEL;
          end
        end else begin
          if (phase_q == tsrg_pkg::PH_ACCEL) begin
            accel_left_d = accel_left_q - 32'd1;
            if (accel_left_q == 32'd1) begin
              phase_d = tsrg_pkg::PH_RUN;
            end
          end else begin
            decel_left_d = decel_left_q - 32'd1;
            if (decel_left_q == 32'd1) begin
              phase_d = tsrg_pkg::PH_DONE;
            end
          end
          if (cper_q != wper_q) begin
            wper_d  = cper_q;
            wrote_d = 1'b1;
          end
        end
      end
    end

    if (cmd_i.ramp) begin
      if (phase_q == tsrg_pkg::PH_ACCEL) begin
        speed_d = speed_sum[32] ? '1 : speed_sum[31:0];
      end else if (phase_q == tsrg_pkg::PH_DECEL) begin
        speed_d = (speed_q > dinc_q) ? (speed_q - dinc_q) : '0;
      end
      if (cmd_i.stop && (phase_q != tsrg_pkg::PH_IDLE)) begin
        phase_d = tsrg_pkg::PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= tsrg_pkg::PH_IDLE;
      pulse_q       <= 1'b0;
      dir_q         <= 1'b0;
      accel_left_q  <= '0;
      cruise_left_q <= '0;
      decel_left_q  <= '0;
      ainc_q        <= '0;
      dinc_q        <= '0;
      speed_q       <= '0;
      cper_q        <= '0;
      wper_q        <= '0;
      wrote_q       <= 1'b0;
      rej_q         <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      pulse_q       <= pulse_d;
      dir_q         <= dir_d;
      accel_left_q  <= accel_left_d;
      cruise_left_q <= cruise_left_d;
      decel_left_q  <= decel_left_d;
      ainc_q        <= ainc_d;
      dinc_q        <= dinc_d;
      speed_q       <= speed_d;
      cper_q        <= cper_d;
      wper_q        <= wper_d;
      wrote_q       <= wrote_d;
      rej_q         <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_ld) begin
      sq_q <= {16'd0, cfg_i.target_speed} * {16'd0, cfg_i.target_speed};
    end
    up_q   <= up_d;
    down_q <= down_d;
  end

  assign res_o.step_level    = pulse_q;
  assign res_o.direction_out = dir_q;
  assign res_o.period_value  = wper_q;
  assign res_o.period_write  = wrote_q;
  assign res_o.phase         = phase_q;
  assign res_o.move_rejected = rej_q;

endmodule

### hw/rtl/tsrg_ctrl.sv
`timescale 1ns / 1ps

module tsrg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      action_i,
  input  logic            stop_hit_i,
  input  logic            out_free_i,
  input  tsrg_pkg::stat_t stat_i,
  output tsrg_pkg::cmd_t  cmd_o,
  output logic            in_stall_o,
  output logic            out_ld_o
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_SQUARE   = 10'b00_0000_0010,
    ST_DIV_UP   = 10'b00_0000_0100,
    ST_DIV_DOWN = 10'b00_0000_1000,
    ST_CHECK    = 10'b00_0001_0000,
    ST_DIV_AINC = 10'b00_0010_0000,
    ST_DIV_DINC = 10'b00_0100_0000,
    ST_RAMP_GO  = 10'b00_1000_0000,
    ST_DIV_PER  = 10'b01_0000_0000,
    ST_EMIT     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.go_sel = tsrg_pkg::SEL_PER;
    cmd_o.ld_sel = tsrg_pkg::SEL_PER;
    cmd_o.stop   = stop_hit_i;
    out_ld_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.clr = 1'b1;
          unique case (action_i)
            tsrg_pkg::ACT_START: begin
              if (stat_i.moving) begin
                state_d = ST_EMIT;
              end else begin
                cmd_o.sq_ld = 1'b1;
                state_d     = ST_SQUARE;
              end
            end
            tsrg_pkg::ACT_STEP: begin
              cmd_o.step = 1'b1;
              state_d    = ST_EMIT;
            end
            tsrg_pkg::ACT_RAMP: begin
              cmd_o.ramp = 1'b1;
              state_d    = ST_RAMP_GO;
            end
            tsrg_pkg::ACT_NONE: state_d = ST_EMIT;
            default:            state_d = ST_EMIT;
          endcase
        end
      end
      ST_SQUARE: begin
        cmd_o.div_go = 1'b1;
        cmd_o.go_sel = tsrg_pkg::SEL_UP;
        state_d      = ST_DIV_UP;
      end
      ST_DIV_UP: begin
        if (stat_i.div_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.ld_sel = tsrg_pkg::SEL_UP;
          cmd_o.div_go = 1'b1;
          cmd_o.go_sel = tsrg_pkg::SEL_DOWN;
          state_d      = ST_DIV_DOWN;
        end
      end
      ST_DIV_DOWN: begin
        if (stat_i.div_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.ld_sel = tsrg_pkg::SEL_DOWN;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.plan_ok) begin
          cmd_o.div_go = 1'b1;
          cmd_o.go_sel = tsrg_pkg::SEL_AINC;
          state_d      = ST_DIV_AINC;
        end else begin
          cmd_o.reject = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_DIV_AINC: begin
        if (stat_i.div_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.ld_sel = tsrg_pkg::SEL_AINC;
          cmd_o.div_go = 1'b1;
          cmd_o.go_sel = tsrg_pkg::SEL_DINC;
          state_d      = ST_DIV_DINC;
        end
      end
      ST_DIV_DINC: begin
        if (stat_i.div_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.ld_sel = tsrg_pkg::SEL_DINC;
          cmd_o.commit = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_RAMP_GO: begin
        cmd_o.div_go = 1'b1;
        cmd_o.go_sel = tsrg_pkg::SEL_PER;
        state_d      = ST_DIV_PER;
      end
      ST_DIV_PER: begin
        if (stat_i.div_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.ld_sel = tsrg_pkg::SEL_PER;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          out_ld_o = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### hw/rtl/trapezoidal_step_ramp_generator_core.sv
`timescale 1ns / 1ps

// channel  handshake                    payload
// in       in_valid_i / in_stall_o      action_i, stop_hit_i
// out      out_valid_o / out_stall_i    step_level_o, direction_out_o, period_value_o,
//                                       period_write_o, phase_o, move_rejected_o
// cfg      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// step tick, idle action, start while moving: result goes via the emit state into the output register
// ramp tick: one 32-step pass of the shared radix-2 divider
// start: square then four divider passes (ramps, increments)
// rejected start: only the two ramp passes
// one beat in flight at a time; a held output beat stalls only the next result
// reset clears the move state (but not the square and ramp lengths) and loads the register defaults

module trapezoidal_step_ramp_generator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic                        stop_hit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        step_level_o,
  output logic                        direction_out_o,
  output logic [31:0]                 period_value_o,
  output logic                        period_write_o,
  output logic [2:0]                  phase_o,
  output logic                        move_rejected_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsrg_pkg::AddrW-1:0]  paddr,
  input  logic [tsrg_pkg::DataW-1:0]  pwdata,
  output logic [tsrg_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  tsrg_pkg::cfg_t  cfg_q;
  tsrg_pkg::cmd_t  cmd;
  tsrg_pkg::stat_t stat;
  tsrg_pkg::res_t  res;
  tsrg_pkg::res_t  out_q;
  logic            out_valid_q;
  logic            out_ld;
  logic            out_free;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[tsrg_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_speed   <= tsrg_pkg::RST_TARGET_SPEED;
      cfg_q.accel_rate     <= tsrg_pkg::RST_ACCEL_RATE;
      cfg_q.decel_rate     <= tsrg_pkg::RST_DECEL_RATE;
      cfg_q.total_steps    <= tsrg_pkg::RST_TOTAL_STEPS;
      cfg_q.move_direction <= tsrg_pkg::RST_MOVE_DIR;
      cfg_q.period_base    <= tsrg_pkg::RST_PERIOD_BASE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tsrg_pkg::REG_TARGET_SPEED:   cfg_q.target_speed   <= pwdata[15:0];
        tsrg_pkg::REG_ACCEL_RATE:     cfg_q.accel_rate     <= pwdata[15:0];
        tsrg_pkg::REG_DECEL_RATE:     cfg_q.decel_rate     <= pwdata[15:0];
        tsrg_pkg::REG_TOTAL_STEPS:    cfg_q.total_steps    <= pwdata;
        tsrg_pkg::REG_MOVE_DIRECTION: cfg_q.move_direction <= pwdata[0];
        tsrg_pkg::REG_PERIOD_BASE:    cfg_q.period_base    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tsrg_pkg::REG_TARGET_SPEED:   prdata = {16'd0, cfg_q.target_speed};
      tsrg_pkg::REG_ACCEL_RATE:     prdata = {16'd0, cfg_q.accel_rate};
      tsrg_pkg::REG_DECEL_RATE:     prdata = {16'd0, cfg_q.decel_rate};
      tsrg_pkg::REG_TOTAL_STEPS:    prdata = cfg_q.total_steps;
      tsrg_pkg::REG_MOVE_DIRECTION: prdata = {31'd0, cfg_q.move_direction};
      tsrg_pkg::REG_PERIOD_BASE:    prdata = cfg_q.period_base;
      default:                      prdata = '0;
    endcase
  end

  tsrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .stop_hit_i (stop_hit_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_ld_o   (out_ld)
  );

  tsrg_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= out_ld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_level_o    = out_q.step_level;
  assign direction_out_o = out_q.direction_out;
  assign period_value_o  = out_q.period_value;
  assign period_write_o  = out_q.period_write;
  assign phase_o         = out_q.phase;
  assign move_rejected_o = out_q.move_rejected;

endmodule
